/* rtl/core/pai_pkg.sv */
// ----------------------------------------------------------------------------
// pai_pkg: shared types and constants
// Capacity, derived widths, operation and status codes, cell control.
// ----------------------------------------------------------------------------
package pai_pkg;

  localparam int CAPACITY = 128;
  localparam int DATA_W   = 32;
  localparam int OP_W     = 3;
  localparam int POS_W    = 8;
  localparam int ST_W     = 2;
  localparam int FILL_W   = 8;

  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam int GRP_N    = 16;
  localparam int NGRP     = (CAPACITY + GRP_N - 1) / GRP_N;

  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [ST_W-1:0] ST_BAD    = 2'd3;

  localparam logic [1:0] CELL_HOLD = 2'd0;
  localparam logic [1:0] CELL_INS  = 2'd1;
  localparam logic [1:0] CELL_DEL  = 2'd2;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [IDX_W-1:0] pos;
    data_t            value;
  } cell_ctrl_t;

endpackage

/* rtl/core/pai_cell.sv */
// ----------------------------------------------------------------------------
// pai_cell: one array slot
// Holds one word; on insert takes its lower neighbor (or the new value at
// the insert position), on delete takes its upper neighbor.
// ----------------------------------------------------------------------------
module pai_cell (
  input  logic                     clk,
  input  logic [pai_pkg::IDX_W-1:0] idx,
  input  pai_pkg::cell_ctrl_t      ctrl,
  input  pai_pkg::data_t           left_data,
  input  pai_pkg::data_t           right_data,
  output pai_pkg::data_t           data,
  output pai_pkg::data_t           rd_data
);
  import pai_pkg::*;

  data_t data_r;
  data_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    case (ctrl.cmd)
      CELL_INS: begin
        if (idx == ctrl.pos) begin
          data_nxt = ctrl.value;
        end else if (idx > ctrl.pos) begin
          data_nxt = left_data;
        end
      end
      CELL_DEL: begin
        if (idx >= ctrl.pos) begin
          data_nxt = right_data;
        end
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data    = data_r;
  assign rd_data = (idx == ctrl.pos) ? data_r : '0;

endmodule

/* rtl/core/positional_array_insert_delete.sv */
// ----------------------------------------------------------------------------
// positional_array_insert_delete: bounded ordered array with positional edit
// Row of word cells with a fill count; insert and delete shift the cells at
// and above the position in parallel, reads go through a registered OR tree.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one operation per item:
//   clear, append, insert at position, delete at position, read.
//   Result channel (out_valid/out_ready) returns one item per operation:
//   status, element (deleted or read word, else zero), fill count after.
//   After acceptance the status, read flag and group OR results are
//   registered, then the output register takes the result. The block
//   holds one item at a time: a new operation is accepted only after the
//   previous result has been taken.
//   On insert and delete the cells at and above the position shift in parallel at the accepting edge.
//   Reset clears the fill count and the handshake state; cell contents are
//   left as they are and only entries below the fill count are ever read.
//   While the receiver stalls, the result is held in the output register
//   and in_ready stays low until it is taken.
// ----------------------------------------------------------------------------
module positional_array_insert_delete (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [pai_pkg::OP_W-1:0]    in_operation,
  input  logic [pai_pkg::POS_W-1:0]   in_position,
  input  logic signed [pai_pkg::DATA_W-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pai_pkg::ST_W-1:0]    out_status,
  output logic signed [pai_pkg::DATA_W-1:0] out_element,
  output logic [pai_pkg::FILL_W-1:0]  out_fill_count
);
  import pai_pkg::*;

  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               pend_r;
  logic               out_valid_r;
  logic [ST_W-1:0]    st_r, st_nxt;
  logic               rd_r, rd_nxt;
  logic [ST_W-1:0]    out_status_r;
  data_t              out_element_r;
  logic [FILL_W-1:0]  out_fill_r;
  data_t              grp_r [NGRP];
  data_t              grp_c [NGRP];
  data_t              or_all;

  cell_ctrl_t         ctrl;
  logic               accept;
  logic [CMP_W-1:0]   pos_c, cnt_c;
  logic               full;

  data_t              cell_q  [CAPACITY];
  data_t              cell_rd [CAPACITY];

  assign accept = in_valid && in_ready;
  assign in_ready = !pend_r && !out_valid_r;
  assign pos_c = CMP_W'(in_position);
  assign cnt_c = CMP_W'(count_r);
  assign full  = (count_r == CNT_W'(CAPACITY));

  always_comb begin
    count_nxt  = count_r;
    st_nxt     = ST_OK;
    rd_nxt     = 1'b0;
    ctrl.cmd   = CELL_HOLD;
    ctrl.pos   = IDX_W'(in_position);
    ctrl.value = in_value;
    case (in_operation)
      OP_CLEAR: begin
        count_nxt = '0;
      end
      OP_APPEND: begin
        if (full) begin
          st_nxt = ST_FULL;
        end else begin
          ctrl.cmd  = CELL_INS;
          ctrl.pos  = IDX_W'(count_r);
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_INSERT: begin
        if (full) begin
          st_nxt = ST_FULL;
        end else if (pos_c > cnt_c) begin
          st_nxt = ST_BAD;
        end else begin
          ctrl.cmd  = CELL_INS;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      OP_DELETE, OP_READ: begin
        if (count_r == '0) begin
          st_nxt = ST_EMPTY;
        end else if (pos_c >= cnt_c) begin
          st_nxt = ST_BAD;
        end else begin
          rd_nxt = 1'b1;
          if (in_operation == OP_DELETE) begin
            ctrl.cmd  = CELL_DEL;
            count_nxt = count_r - CNT_W'(1);
          end
        end
      end
      default: count_nxt = count_r;
    endcase
    if (!accept) begin
      ctrl.cmd = CELL_HOLD;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      data_t left_d, right_d;
      if (gi == 0) begin : g_first
        assign left_d = '0;
      end else begin : g_mid
        assign left_d = cell_q[gi-1];
      end
      if (gi == CAPACITY - 1) begin : g_last
        assign right_d = cell_q[gi];
      end else begin : g_inner
        assign right_d = cell_q[gi+1];
      end
      pai_cell u_cell (
        .clk        (clk),
        .idx        (IDX_W'(gi)),
        .ctrl       (ctrl),
        .left_data  (left_d),
        .right_data (right_d),
        .data       (cell_q[gi]),
        .rd_data    (cell_rd[gi])
      );
    end
  endgenerate

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_c[g] = '0;
      for (int j = 0; j < GRP_N; j++) begin
        if (g * GRP_N + j < CAPACITY) begin
          grp_c[g] = grp_c[g] | cell_rd[g * GRP_N + j];
        end
      end
    end
  end

  always_comb begin
    or_all = '0;
    for (int g = 0; g < NGRP; g++) begin
      or_all = or_all | grp_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      st_r <= st_nxt;
      rd_r <= rd_nxt;
      for (int g = 0; g < NGRP; g++) begin
        grp_r[g] <= grp_c[g];
      end
    end
    if (pend_r) begin
      out_status_r  <= st_r;
      out_element_r <= rd_r ? or_all : '0;
      out_fill_r    <= FILL_W'(count_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      pend_r <= accept;
      if (pend_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_element    = out_element_r;
  assign out_fill_count = out_fill_r;

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    !(pend_r && out_valid_r))
    else $error("pending item while result register is occupied");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("fill count above capacity");

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_operation == OP_CLEAR) |=> (count_r == '0))
    else $error("clear did not empty the array");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_element_r == '0))
    else $error("error result carries a nonzero element");

endmodule
